// File: rtl/rtzw_pkg.sv
// Package for the radar target zone warning block.
// Holds field widths, register indexes and reset values, the shared structs and the sine table.
// No dependencies.
package rtzw_pkg;

  localparam int TRIG_FRACTION_BITS = 15;
  localparam int TRIG_W = TRIG_FRACTION_BITS;

  localparam int SINE_DEPTH = 361;
  localparam int SINE_AW = 9;

  localparam int CAN_ID_W = 11;
  localparam int DATA_W = 64;
  localparam int RANGE_W = 13;
  localparam int RANGE20_W = 18;
  localparam int SPEED_W = 11;
  localparam int ANGLE_W = 10;
  localparam int PROD_W = RANGE20_W + TRIG_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_FRAME_ID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATERAL_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONGITUDINAL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_APPROACH_SPEED_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_SECONDS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT = 3'd5;

  localparam logic [10:0] RST_OBJECT_FRAME_ID = 11'h6B0;
  localparam logic [15:0] RST_LATERAL_LIMIT = 16'd150;
  localparam logic [15:0] RST_LONGITUDINAL_LIMIT = 16'd13000;
  localparam logic signed [10:0] RST_APPROACH_SPEED_LIMIT = -11'sd1;
  localparam logic [7:0] RST_TIMEOUT_SECONDS = 8'd1;
  localparam logic [3:0] RST_MISS_LIMIT = 4'd10;

  localparam logic [9:0] QUARTER_TURN_QD = 10'd360;
  localparam logic [10:0] HALF_TURN_QD = 11'd720;

  typedef struct packed {
    logic [10:0] object_frame_id;
    logic [15:0] lateral_limit_cm;
    logic [15:0] longitudinal_limit_cm;
    logic signed [10:0] approach_speed_limit;
    logic [7:0] timeout_seconds;
    logic [3:0] miss_limit;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic obj;
    logic approach;
    logic cos_neg;
    logic [RANGE20_W-1:0] range20;
    logic [SINE_AW-1:0] sin_addr;
    logic [SINE_AW-1:0] cos_addr;
  } cmd_t;

  typedef struct packed {
    logic warning_on;
    logic warning_raised;
    logic warning_cleared;
  } res_t;

  typedef logic [TRIG_W-1:0] sine_tab_t [0:SINE_DEPTH-1];

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] top;
    top = (64'd1 << TRIG_W) - 64'd1;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      theta = (64'(k) * PI_Q30 + 64'd360) / 64'd720;
      t2 = (theta * theta) >> 30;
      term = theta;
      sum = theta;
      term = ((term * t2) >> 30) / 64'd6;
      sum = sum - term;
      term = ((term * t2) >> 30) / 64'd20;
      sum = sum + term;
      term = ((term * t2) >> 30) / 64'd42;
      sum = sum - term;
      term = ((term * t2) >> 30) / 64'd72;
      sum = sum + term;
      term = ((term * t2) >> 30) / 64'd110;
      sum = sum - term;
      term = ((term * t2) >> 30) / 64'd156;
      sum = sum + term;
      e = (sum + (64'd1 << (29 - TRIG_W))) >> (30 - TRIG_W);
      if (e > top) begin
        e = top;
      end
      tab[k] = e[TRIG_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: rtl/rtzw_front.sv
// Front end: configuration registers, item acceptance, frame classification and command queue.
// Depends on rtzw_pkg.
module rtzw_front import rtzw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_kind,
  input  logic [CAN_ID_W-1:0]   in_can_id,
  input  logic [DATA_W-1:0]     in_frame_data,
  output logic                  in_full,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  output cfg_t                  cfg,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_pop
);

  localparam int CMD_AW = $clog2(CMD_DEPTH);
  localparam int CMD_CW = $clog2(CMD_DEPTH + 1);

  cfg_t cfg_r;
  cmd_t cmd_mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_r;
  logic [CMD_AW-1:0] rd_ptr_r;
  logic [CMD_CW-1:0] cnt_r;

  logic push;
  logic [ANGLE_W-1:0] angle_mag;
  logic [RANGE_W-1:0] range_raw;
  cmd_t cmd_new;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.object_frame_id <= RST_OBJECT_FRAME_ID;
      cfg_r.lateral_limit_cm <= RST_LATERAL_LIMIT;
      cfg_r.longitudinal_limit_cm <= RST_LONGITUDINAL_LIMIT;
      cfg_r.approach_speed_limit <= RST_APPROACH_SPEED_LIMIT;
      cfg_r.timeout_seconds <= RST_TIMEOUT_SECONDS;
      cfg_r.miss_limit <= RST_MISS_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OBJECT_FRAME_ID: cfg_r.object_frame_id <= cfg_data[10:0];
        REG_LATERAL_LIMIT: cfg_r.lateral_limit_cm <= cfg_data;
        REG_LONGITUDINAL_LIMIT: cfg_r.longitudinal_limit_cm <= cfg_data;
        REG_APPROACH_SPEED_LIMIT: cfg_r.approach_speed_limit <= $signed(cfg_data[10:0]);
        REG_TIMEOUT_SECONDS: cfg_r.timeout_seconds <= cfg_data[7:0];
        REG_MISS_LIMIT: cfg_r.miss_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    range_raw = in_frame_data[55:43];
    angle_mag = in_frame_data[31] ? (~in_frame_data[31:22] + 10'd1) : in_frame_data[31:22];
    cmd_new.tick = in_kind;
    cmd_new.obj = !in_kind && (in_can_id == cfg_r.object_frame_id);
    cmd_new.approach = $signed(in_frame_data[42:32]) <= cfg_r.approach_speed_limit;
    cmd_new.cos_neg = angle_mag > QUARTER_TURN_QD;
    cmd_new.range20 = {1'b0, range_raw, 4'b0} + {3'b0, range_raw, 2'b0};
    if (angle_mag <= QUARTER_TURN_QD) begin
      cmd_new.sin_addr = angle_mag[SINE_AW-1:0];
      cmd_new.cos_addr = SINE_AW'(QUARTER_TURN_QD - angle_mag);
    end else begin
      cmd_new.sin_addr = SINE_AW'(HALF_TURN_QD - {1'b0, angle_mag});
      cmd_new.cos_addr = SINE_AW'(angle_mag - QUARTER_TURN_QD);
    end
  end

  assign in_full = (cnt_r == CMD_CW'(CMD_DEPTH));
  assign push = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = cmd_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem_r[wr_ptr_r] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, cmd_pop})
        2'b10: cnt_r <= cnt_r + 1'b1;
        2'b01: cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/rtzw_back.sv
// Back end: sine table reads, position multiplies, zone test, warning state and result queue.
// Depends on rtzw_pkg.
module rtzw_back import rtzw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_empty,
  output res_t res,
  input  logic out_pop
);

  localparam int OUT_AW = $clog2(OUT_DEPTH);
  localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
  localparam int SUM_W = $clog2(OUT_DEPTH + 3);

  logic v0_r;
  cmd_t c0_r;
  logic [TRIG_W-1:0] sin0_r;
  logic [TRIG_W-1:0] cos0_r;

  logic v1_r;
  logic tick1_r;
  logic obj1_r;
  logic appr1_r;
  logic cneg1_r;
  logic [PROD_W-1:0] x1_r;
  logic [PROD_W-1:0] y1_r;

  logic level_r;
  logic [7:0] sec_r;
  logic [3:0] miss_r;
  logic level_nxt;
  logic [7:0] sec_nxt;
  logic [3:0] miss_nxt;
  logic [4:0] miss_wide;

  logic [PROD_W-1:0] lat_scaled;
  logic [PROD_W-1:0] lon_scaled;
  logic in_zone;
  res_t res_new;

  res_t out_mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0] out_wr_r;
  logic [OUT_AW-1:0] out_rd_r;
  logic [OUT_CW-1:0] out_cnt_r;
  logic out_take;

  assign cmd_pop = cmd_valid &&
      ((SUM_W'(out_cnt_r) + SUM_W'(v0_r) + SUM_W'(v1_r)) < SUM_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      c0_r <= cmd;
      sin0_r <= SINE_TAB[cmd.sin_addr];
      cos0_r <= SINE_TAB[cmd.cos_addr];
    end
    if (v0_r) begin
      tick1_r <= c0_r.tick;
      obj1_r <= c0_r.obj;
      appr1_r <= c0_r.approach;
      cneg1_r <= c0_r.cos_neg;
      x1_r <= c0_r.range20 * sin0_r;
      y1_r <= c0_r.range20 * cos0_r;
    end
  end

  always_comb begin
    lat_scaled = PROD_W'({cfg.lateral_limit_cm, {TRIG_W{1'b0}}});
    lon_scaled = PROD_W'({cfg.longitudinal_limit_cm, {TRIG_W{1'b0}}});
    in_zone = (x1_r < lat_scaled) && !cneg1_r && (y1_r != '0) && (y1_r < lon_scaled);
  end

  always_comb begin
    level_nxt = level_r;
    sec_nxt = sec_r;
    miss_wide = {1'b0, miss_r};
    res_new.warning_raised = 1'b0;
    res_new.warning_cleared = 1'b0;
    if (v1_r) begin
      if (tick1_r) begin
        if (sec_r != 8'hFF) begin
          sec_nxt = sec_r + 8'd1;
        end
      end else begin
        if (obj1_r && in_zone) begin
          if (appr1_r) begin
            level_nxt = 1'b1;
            sec_nxt = '0;
            miss_wide = '0;
            res_new.warning_raised = 1'b1;
          end else begin
            miss_wide = miss_wide + 5'd1;
          end
        end
        if ((sec_nxt > cfg.timeout_seconds) || (miss_wide > {1'b0, cfg.miss_limit})) begin
          res_new.warning_cleared = level_nxt;
          level_nxt = 1'b0;
          miss_wide = '0;
        end
      end
    end
    miss_nxt = miss_wide[3:0];
    res_new.warning_on = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      level_r <= 1'b0;
      sec_r <= '0;
      miss_r <= '0;
    end else begin
      v0_r <= cmd_pop;
      v1_r <= v0_r;
      level_r <= level_nxt;
      sec_r <= sec_nxt;
      miss_r <= miss_nxt;
    end
  end

  assign out_empty = (out_cnt_r == '0);
  assign out_take = out_pop && !out_empty;
  assign res = out_mem_r[out_rd_r];

  always_ff @(posedge clk) begin
    if (v1_r) begin
      out_mem_r[out_wr_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_r <= '0;
      out_rd_r <= '0;
      out_cnt_r <= '0;
    end else begin
      if (v1_r) begin
        out_wr_r <= out_wr_r + 1'b1;
      end
      if (out_take) begin
        out_rd_r <= out_rd_r + 1'b1;
      end
      unique case ({v1_r, out_take})
        2'b10: out_cnt_r <= out_cnt_r + 1'b1;
        2'b01: out_cnt_r <= out_cnt_r - 1'b1;
        default: out_cnt_r <= out_cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/radar_target_zone_warning.sv
// Top level of the radar target zone warning block: front end and back end joined by a command queue.
// Path: an item goes through the command queue, the back-end registers and the result queue.
// Throughput: one item per cycle while results drain, set by back end and four-entry result queue.
// Reset: synchronous and active low; it restores the register defaults and clears the warning,
// the timers and both queues.
// Depends on rtzw_pkg, rtzw_front and rtzw_back.
module radar_target_zone_warning import rtzw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_kind,
  input  logic [CAN_ID_W-1:0]   in_can_id,
  input  logic [DATA_W-1:0]     in_frame_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_warning_on,
  output logic                  out_warning_raised,
  output logic                  out_warning_cleared,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  rtzw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_kind       (in_kind),
    .in_can_id     (in_can_id),
    .in_frame_data (in_frame_data),
    .in_full       (in_full),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg_ready     (cfg_ready),
    .cfg           (cfg),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  rtzw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .res       (res),
    .out_pop   (out_pop)
  );

  assign out_warning_on = res.warning_on;
  assign out_warning_raised = res.warning_raised;
  assign out_warning_cleared = res.warning_cleared;

endmodule

// File: rtl/rtzw_checker.sv
// Port-level checker for the radar target zone warning block, bound to the top level.
// Depends on radar_target_zone_warning.
module rtzw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input logic out_warning_on,
  input logic out_warning_raised,
  input logic out_warning_cleared
);

  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> (out_empty && !in_full))
    else $error("Queues are not empty after reset.");

  a_raise_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && out_warning_raised) |-> out_warning_on)
    else $error("A raised warning is not shown as on.");

  a_clear_drops_level: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && out_warning_cleared) |-> (!out_warning_on && !out_warning_raised))
    else $error("A cleared warning is still shown as on.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && !out_pop) |=> (!out_empty &&
      $stable({out_warning_on, out_warning_raised, out_warning_cleared})))
    else $error("A waiting result changed before its transfer.");

endmodule

bind radar_target_zone_warning rtzw_checker u_rtzw_checker (.*);
